@@ rtl/des_pkg.sv @@
// Package for the descending exchange sort core: record and result beat types,
// microcode field codes, step codes and the microcode table.
// Has no dependencies; the sequencer, the datapath and the top level import it.
package des_pkg;

	localparam int MAX_RECORDS_DEF = 32;
	localparam int KEY_W = 32;
	localparam int ID_W = 10;

	// Input beat: one record.
	typedef struct packed {
		logic [KEY_W-1:0] access_count;
		logic [ID_W-1:0]  record_id;
		logic             is_last;
	} rec_beat_t;

	// Output beat: one sorted record.
	typedef struct packed {
		logic [KEY_W-1:0] sorted_count;
		logic [ID_W-1:0]  sorted_id;
		logic             last_out;
		logic             overflowed;
	} res_beat_t;

	// A record as it sits in the record memory.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} rec_t;

	// When a step fires.
	typedef enum logic [1:0] {G_ALWAYS = 2'd0, G_IN = 2'd1, G_OUT = 2'd2} go_t;
	// Branch condition, tested when the step fires.
	typedef enum logic [2:0] {
		J_NEVER = 3'd0, J_LAST = 3'd1, J_JEND = 3'd2, J_JNEND = 3'd3,
		J_IEND = 3'd4, J_KEND = 3'd5
	} jc_t;
	// Read address select.
	typedef enum logic [2:0] {
		RA_I = 3'd0, RA_J = 3'd1, RA_JN = 3'd2, RA_K = 3'd3, RA_KN = 3'd4
	} ra_t;
	// Write port use.
	typedef enum logic [1:0] {W_NONE = 2'd0, W_LOAD = 2'd1, W_SWAP = 2'd2, W_HOME = 2'd3} wr_t;
	// Held record register.
	typedef enum logic [1:0] {A_HOLD = 2'd0, A_LOAD = 2'd1, A_SWAP = 2'd2} aop_t;
	// Counter operations.
	typedef enum logic [1:0] {C_HOLD = 2'd0, C_CLR = 2'd1, C_INC = 2'd2, C_INIT = 2'd3} cop_t;
	// Fill count and overflow flag.
	typedef enum logic [1:0] {F_HOLD = 2'd0, F_LOAD = 2'd1, F_CLR = 2'd2} fop_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_LOAD  = 3'd0;
	localparam step_t STEP_IRD   = 3'd1;
	localparam step_t STEP_ILAT  = 3'd2;
	localparam step_t STEP_JCMP  = 3'd3;
	localparam step_t STEP_IWR   = 3'd4;
	localparam step_t STEP_ORD   = 3'd5;
	localparam step_t STEP_OWAIT = 3'd6;
	localparam step_t STEP_DONE  = 3'd7;

	// One control word.
	typedef struct packed {
		go_t   go;
		jc_t   jc;
		step_t jt;
		step_t nt;
		ra_t   ra;
		wr_t   wr;
		aop_t  aop;
		cop_t  iop;
		cop_t  jop;
		cop_t  kop;
		fop_t  fop;
		logic  out_ld;
	} cw_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic last_in;
		logic j_end;
		logic jn_end;
		logic i_end;
		logic k_end;
		logic out_free;
	} st_t;

	// Microcode table. Position i holds a record in a register while every later
	// position j is compared against it; the loser goes back to j.
	function automatic cw_t ucode(input step_t step);
		cw_t w;
		w = '{go: G_ALWAYS, jc: J_NEVER, jt: STEP_LOAD, nt: STEP_LOAD, ra: RA_I,
			wr: W_NONE, aop: A_HOLD, iop: C_HOLD, jop: C_HOLD, kop: C_HOLD,
			fop: F_HOLD, out_ld: 1'b0};
		unique case (step)
			STEP_LOAD: begin
				w.go = G_IN; w.jc = J_LAST; w.jt = STEP_IRD; w.nt = STEP_LOAD;
				w.wr = W_LOAD; w.iop = C_CLR; w.fop = F_LOAD;
			end
			STEP_IRD: begin
				w.nt = STEP_ILAT; w.ra = RA_I; w.jop = C_INIT;
			end
			STEP_ILAT: begin
				w.jc = J_JEND; w.jt = STEP_IWR; w.nt = STEP_JCMP;
				w.ra = RA_J; w.aop = A_LOAD;
			end
			STEP_JCMP: begin
				w.jc = J_JNEND; w.jt = STEP_IWR; w.nt = STEP_JCMP;
				w.ra = RA_JN; w.wr = W_SWAP; w.aop = A_SWAP; w.jop = C_INC;
			end
			STEP_IWR: begin
				w.jc = J_IEND; w.jt = STEP_ORD; w.nt = STEP_IRD;
				w.wr = W_HOME; w.iop = C_INC; w.kop = C_CLR;
			end
			STEP_ORD: begin
				w.nt = STEP_OWAIT; w.ra = RA_K;
			end
			STEP_OWAIT: begin
				w.go = G_OUT; w.jc = J_KEND; w.jt = STEP_DONE; w.nt = STEP_OWAIT;
				w.ra = RA_KN; w.kop = C_INC; w.out_ld = 1'b1;
			end
			STEP_DONE: begin
				w.nt = STEP_LOAD; w.fop = F_CLR;
			end
		endcase
		return w;
	endfunction

endpackage

@@ rtl/descending_exchange_sort_core.sv @@
// Top level of the descending exchange sort core: sequencer plus datapath.
// Depends on des_pkg, des_seq and des_dp.
//
//   channel  beat          handshake            direction
//   rec      rec_beat_t    rec_valid/rec_stall  in: one record per beat
//   res      res_beat_t    res_valid/res_stall  out: one sorted record per beat
//
// Records load at one beat per cycle. After the beat marked last, the sort of
// the held records does one compare per cycle through the single write port of
// the record memory; output then takes a read setup step (ORD), one cycle per
// beat while res is not stalled, and a closing step (DONE).
// rec_stall is high from the last beat until the DONE step that follows the
// final beat of the run entering the output register has passed. Reset is
// asynchronous, active low, and empties the core; memory contents are not reset.
module descending_exchange_sort_core #(
	parameter int MaxRecords = des_pkg::MAX_RECORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_stall,
	input  des_pkg::rec_beat_t  rec,
	output logic                res_valid,
	input  logic                res_stall,
	output des_pkg::res_beat_t  res
);
	import des_pkg::*;

	cw_t  cw;
	st_t  st;
	logic go;

	des_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.st        (st),
		.cw        (cw),
		.go        (go),
		.rec_stall (rec_stall)
	);

	des_dp #(
		.MaxRecords (MaxRecords)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.go        (go),
		.rec       (rec),
		.res_stall (res_stall),
		.st        (st),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

@@ rtl/des_seq.sv @@
// Microcode sequencer: step counter, control word lookup and branch logic.
// Depends on des_pkg for the control word, status types and microcode table.
module des_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  des_pkg::st_t   st,
	output des_pkg::cw_t   cw,
	output logic           go,
	output logic           rec_stall
);
	import des_pkg::*;

	step_t upc_q;
	logic  take;

	// Current control word.
	assign cw = ucode(upc_q);

	// The step fires when its wait condition holds.
	always_comb begin
		unique case (cw.go)
			G_ALWAYS: go = 1'b1;
			G_IN:     go = rec_valid;
			G_OUT:    go = st.out_free;
			default:  go = 1'b0;
		endcase
	end

	// Branch condition.
	always_comb begin
		unique case (cw.jc)
			J_NEVER: take = 1'b0;
			J_LAST:  take = st.last_in;
			J_JEND:  take = st.j_end;
			J_JNEND: take = st.jn_end;
			J_IEND:  take = st.i_end;
			J_KEND:  take = st.k_end;
			default: take = 1'b0;
		endcase
	end

	// Input is only taken in the load step.
	assign rec_stall = (cw.go != G_IN);

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_LOAD;
		end else if (go) begin
			upc_q <= take ? cw.jt : cw.nt;
		end
	end

endmodule

@@ rtl/des_dp.sv @@
// Datapath: record memory, held record register, position counters, fill count
// and the output register. Driven by control words from des_seq.
// Depends on des_pkg for beat, record, control and status types.
module des_dp #(
	parameter int MaxRecords = des_pkg::MAX_RECORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  des_pkg::cw_t        cw,
	input  logic                go,
	input  des_pkg::rec_beat_t  rec,
	input  logic                res_stall,
	output des_pkg::st_t        st,
	output logic                res_valid,
	output des_pkg::res_beat_t  res
);
	import des_pkg::*;

	localparam int AW = $clog2(MaxRecords);
	localparam int CW = $clog2(MaxRecords + 1);

	rec_t           mem [MaxRecords];
	rec_t           rd_q;
	rec_t           a_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  i_q;
	logic [CW-1:0]  j_q;
	logic [CW-1:0]  k_q;
	logic           ovf_q;
	logic           res_valid_q;
	res_beat_t      res_q;

	logic [CW-1:0]  raddr;
	logic           we;
	logic [AW-1:0]  waddr;
	rec_t           wdata;
	logic           larger;
	logic           full;
	logic [CW-1:0]  i_nx;
	logic [CW-1:0]  j_nx;
	logic [CW-1:0]  k_nx;

	assign full   = (fill_q == CW'(MaxRecords));
	assign larger = (rd_q.key > a_q.key);
	assign i_nx   = i_q + CW'(1);
	assign j_nx   = j_q + CW'(1);
	assign k_nx   = k_q + CW'(1);

	// Status for the sequencer branches.
	assign st.last_in  = rec.is_last;
	assign st.j_end    = (j_q == fill_q);
	assign st.jn_end   = (j_nx == fill_q);
	assign st.i_end    = (i_nx == fill_q);
	assign st.k_end    = (k_nx == fill_q);
	assign st.out_free = !res_valid_q || !res_stall;

	// Read address; the output step moves on only when the output register is free.
	always_comb begin
		unique case (cw.ra)
			RA_I:    raddr = i_q;
			RA_J:    raddr = j_q;
			RA_JN:   raddr = j_nx;
			RA_K:    raddr = k_q;
			RA_KN:   raddr = go ? k_nx : k_q;
			default: raddr = i_q;
		endcase
	end

	// Write port: load a record, return the loser of a compare, or put the
	// held record home at position i.
	always_comb begin
		we    = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = a_q;
		unique case (cw.wr)
			W_NONE: we = 1'b0;
			W_LOAD: begin
				we    = go && !full;
				waddr = fill_q[AW-1:0];
				wdata = '{key: rec.access_count, id: rec.record_id};
			end
			W_SWAP: begin
				we    = go && larger;
				waddr = j_q[AW-1:0];
			end
			W_HOME: we = go;
			default: we = 1'b0;
		endcase
	end

	// Record memory with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr[AW-1:0]];
	end

	// Held record at position i.
	always_ff @(posedge clk) begin
		if (go && (cw.aop == A_LOAD || (cw.aop == A_SWAP && larger))) begin
			a_q <= rd_q;
		end
	end

	// Position counters, fill count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (go) begin
			unique case (cw.iop)
				C_CLR:   i_q <= '0;
				C_INC:   i_q <= i_nx;
				default: i_q <= i_q;
			endcase
			unique case (cw.jop)
				C_INIT:  j_q <= i_nx;
				C_INC:   j_q <= j_nx;
				default: j_q <= j_q;
			endcase
			unique case (cw.kop)
				C_CLR:   k_q <= '0;
				C_INC:   k_q <= k_nx;
				default: k_q <= k_q;
			endcase
			unique case (cw.fop)
				F_LOAD: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						fill_q <= fill_q + CW'(1);
					end
				end
				F_CLR: begin
					fill_q <= '0;
					ovf_q  <= 1'b0;
				end
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && cw.out_ld) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && cw.out_ld) begin
			res_q <= '{sorted_count: rd_q.key, sorted_id: rd_q.id,
				last_out: st.k_end, overflowed: ovf_q};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
